@@ sv/mm_pkg.sv @@
// Shared constants, codes and the control type for the matrix multiply block.
package mm_pkg;

  localparam int MAX_DIM_DEFAULT   = 16;
  localparam int ELEM_BITS_DEFAULT = 16;

  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CMD_W     = 2;
  localparam int INDEX_W   = 4;
  localparam int VALUE_W   = 16;
  localparam int PRODUCT_W = 36;

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(16);

  localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIDDEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS   = 2'd2;

  localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

  typedef struct packed {
    logic clear;
    logic valid;
    logic last;
  } mac_ctrl_t;

endpackage

@@ sv/mm_ram.sv @@
// Single-port-write, single-port-read synchronous memory holding one matrix.
module mm_ram #(
  parameter int DEPTH = mm_pkg::MAX_DIM_DEFAULT * mm_pkg::MAX_DIM_DEFAULT,
  parameter int WIDTH = mm_pkg::ELEM_BITS_DEFAULT,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);
  import mm_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/mm_mac.sv @@
// Multiply-accumulate unit: registered product, then a running Q20.16 sum.
module mm_mac #(
  parameter int ELEM_BITS = mm_pkg::ELEM_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  mm_pkg::mac_ctrl_t                  ctrl,
  input  logic signed [ELEM_BITS-1:0]        a_elem,
  input  logic signed [ELEM_BITS-1:0]        b_elem,
  output logic [mm_pkg::PRODUCT_W-1:0]       acc,
  output logic                               done
);
  import mm_pkg::*;

  logic signed [2*ELEM_BITS-1:0] mul;
  logic                          mul_valid;
  logic                          mul_last;
  logic [PRODUCT_W-1:0]          mul_ext;

  assign mul_ext = PRODUCT_W'(mul);

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      mul_last  <= 1'b0;
      done      <= 1'b0;
    end else begin
      mul_valid <= ctrl.valid;
      mul_last  <= ctrl.valid && ctrl.last;
      done      <= mul_valid && mul_last;
    end
    mul <= a_elem * b_elem;
    if (ctrl.clear) begin
      acc <= '0;
    end else if (mul_valid) begin
      acc <= acc + mul_ext;
    end
  end

endmodule

@@ sv/matrix_multiply.sv @@
// Top level of the matrix multiply block: command decode, sequencing and result register.
//
// Writes store one Q8.8 element of A or B; their status goes out through the result
// register, waiting in HOLD while the output stalls. A read of C walks the hidden
// dimension with one multiply-accumulate per cycle, fed by one read port on each matrix
// memory; the accumulated sum is registered as the result, and a read with hidden set to
// zero answers at once with zero. Out-of-range indexes, and register values above
// MAX_DIM, which act as MAX_DIM, follow the rules of the command set.
module matrix_multiply #(
  parameter int MAX_DIM   = mm_pkg::MAX_DIM_DEFAULT,
  parameter int ELEM_BITS = mm_pkg::ELEM_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [mm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mm_pkg::CFG_W-1:0]          cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mm_pkg::CMD_W-1:0]          command,
  input  logic [mm_pkg::INDEX_W-1:0]        row,
  input  logic [mm_pkg::INDEX_W-1:0]        column,
  input  logic signed [mm_pkg::VALUE_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [mm_pkg::PRODUCT_W-1:0] product,
  output logic                              status
);
  import mm_pkg::*;

  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DIM_CNT_W = $clog2(MAX_DIM + 1);
  localparam int CMP_W     = (DIM_CNT_W > CFG_W) ? DIM_CNT_W : CFG_W;
  localparam logic [CMP_W-1:0] DIM_MAX = CMP_W'(MAX_DIM);
  localparam logic [ADDR_W-1:0] STRIDE = ADDR_W'(MAX_DIM);

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    HOLD
  } state_t;

  state_t state;

  logic [CFG_W-1:0] rows;
  logic [CFG_W-1:0] hidden;
  logic [CFG_W-1:0] cols;

  logic [CMP_W-1:0] num_rows;
  logic [CMP_W-1:0] num_hidden;
  logic [CMP_W-1:0] num_cols;
  logic [CMP_W-1:0] row_ext;
  logic [CMP_W-1:0] col_ext;

  logic accept;
  logic slot_free;
  logic a_ok;
  logic b_ok;
  logic r_ok;
  logic write_a;
  logic write_b;
  logic start_run;
  logic imm_status;

  logic                 res_valid;
  logic [PRODUCT_W-1:0] res_product;
  logic                 res_status;
  logic [PRODUCT_W-1:0] pend_product;
  logic                 pend_status;

  logic [INDEX_W-1:0] rd_row;
  logic [INDEX_W-1:0] rd_col;
  logic [CMP_W-1:0]   k;
  logic               issuing;
  logic               k_last;
  logic               data_valid;
  logic               data_last;

  logic [ADDR_W-1:0]          wr_addr;
  logic [ADDR_W-1:0]          a_rd_addr;
  logic [ADDR_W-1:0]          b_rd_addr;
  logic [ELEM_BITS-1:0]       elem;
  logic signed [ELEM_BITS-1:0] a_elem;
  logic signed [ELEM_BITS-1:0] b_elem;

  mac_ctrl_t            mac_ctrl;
  logic [PRODUCT_W-1:0] acc;
  logic                 mac_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows   <= DIM_RESET;
      hidden <= DIM_RESET;
      cols   <= DIM_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROWS:   rows   <= cfg_data;
        REG_HIDDEN: hidden <= cfg_data;
        REG_COLS:   cols   <= cfg_data;
        default:    ;
      endcase
    end
  end

  assign num_rows   = (CMP_W'(rows) > DIM_MAX) ? DIM_MAX : CMP_W'(rows);
  assign num_hidden = (CMP_W'(hidden) > DIM_MAX) ? DIM_MAX : CMP_W'(hidden);
  assign num_cols   = (CMP_W'(cols) > DIM_MAX) ? DIM_MAX : CMP_W'(cols);
  assign row_ext    = CMP_W'(row);
  assign col_ext    = CMP_W'(column);

  assign in_stall  = (state != IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  assign a_ok = (row_ext < num_rows) && (col_ext < num_hidden);
  assign b_ok = (row_ext < num_hidden) && (col_ext < num_cols);
  assign r_ok = (row_ext < num_rows) && (col_ext < num_cols);

  assign write_a   = accept && (command == CMD_WRITE_A) && a_ok;
  assign write_b   = accept && (command == CMD_WRITE_B) && b_ok;
  assign start_run = accept && (command == CMD_READ) && r_ok && (num_hidden != '0);

  assign imm_status = !(((command == CMD_WRITE_A) && a_ok) ||
                        ((command == CMD_WRITE_B) && b_ok) ||
                        ((command == CMD_READ) && r_ok));

  assign res_valid   = (accept && !start_run) || mac_done;
  assign res_product = mac_done ? acc : '0;
  assign res_status  = mac_done ? 1'b0 : imm_status;

  assign k_last = (k == num_hidden - CMP_W'(1));

  assign wr_addr   = ADDR_W'(row) * STRIDE + ADDR_W'(column);
  assign a_rd_addr = ADDR_W'(rd_row) * STRIDE + ADDR_W'(k);
  assign b_rd_addr = ADDR_W'(k) * STRIDE + ADDR_W'(rd_col);
  assign elem      = ELEM_BITS'(value);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      out_valid  <= 1'b0;
      issuing    <= 1'b0;
      data_valid <= 1'b0;
      data_last  <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (start_run) begin
            state <= RUN;
          end else if (res_valid && !slot_free) begin
            state <= HOLD;
          end
        end
        RUN: begin
          if (mac_done) begin
            state <= slot_free ? IDLE : HOLD;
          end
        end
        HOLD: begin
          if (slot_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase

      if (res_valid && slot_free) begin
        out_valid <= 1'b1;
        product   <= res_product;
        status    <= res_status;
      end else if (state == HOLD && slot_free) begin
        out_valid <= 1'b1;
        product   <= pend_product;
        status    <= pend_status;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (start_run) begin
        issuing <= 1'b1;
        k       <= '0;
        rd_row  <= row;
        rd_col  <= column;
      end else if (issuing) begin
        k <= k + CMP_W'(1);
        if (k_last) begin
          issuing <= 1'b0;
        end
      end

      data_valid <= issuing;
      data_last  <= issuing && k_last;
    end

    if (res_valid && !slot_free) begin
      pend_product <= res_product;
      pend_status  <= res_status;
    end
  end

  assign mac_ctrl.clear = start_run;
  assign mac_ctrl.valid = data_valid;
  assign mac_ctrl.last  = data_last;

  mm_ram #(
    .DEPTH (DEPTH),
    .WIDTH (ELEM_BITS),
    .ADDR_W(ADDR_W)
  ) u_left (
    .clk    (clk),
    .wr_en  (write_a),
    .wr_addr(wr_addr),
    .wr_data(elem),
    .rd_en  (issuing),
    .rd_addr(a_rd_addr),
    .rd_data(a_elem)
  );

  mm_ram #(
    .DEPTH (DEPTH),
    .WIDTH (ELEM_BITS),
    .ADDR_W(ADDR_W)
  ) u_right (
    .clk    (clk),
    .wr_en  (write_b),
    .wr_addr(wr_addr),
    .wr_data(elem),
    .rd_en  (issuing),
    .rd_addr(b_rd_addr),
    .rd_data(b_elem)
  );

  mm_mac #(
    .ELEM_BITS(ELEM_BITS)
  ) u_mac (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (mac_ctrl),
    .a_elem(a_elem),
    .b_elem(b_elem),
    .acc   (acc),
    .done  (mac_done)
  );

endmodule
